### rtl/core/rps_pkg.sv
`default_nettype none
package rps_pkg;

  localparam int unsigned MaxProcsDef = 64;
  localparam int unsigned TimeW       = 23;
  localparam int unsigned PidW        = 7;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_REJECTED    = 3'd1,
    ST_RUN_STARTED = 3'd2,
    ST_CPU_IDLE    = 3'd3,
    ST_RAN_UNIT    = 3'd4,
    ST_ALL_DONE    = 3'd5,
    ST_CLEARED     = 3'd6,
    ST_EMPTY       = 3'd7
  } status_e;

  typedef enum logic {
    CFG_MODE    = 1'b0,
    CFG_QUANTUM = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_COPY, S_ADM, S_BEST, S_POP1, S_POP2, S_PICK,
    S_RUN1, S_RUN2, S_FIN1, S_FIN2, S_FIN3, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] burst;
    logic [7:0]  priority_req;
    logic [15:0] arrival;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [PidW-1:0]  pid;
    logic [TimeW-1:0] start_time;
    logic [PidW-1:0]  preempted_pid;
    logic             quantum_expired;
    logic             completed;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [TimeW-1:0] response;
  } out_word_t;

  typedef struct packed {
    logic admit;
    logic eligible;
    logic better;
  } scan_res_t;

endpackage
`default_nettype wire

### rtl/core/rps_ram.sv
`default_nettype none
module rps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/core/rps_scan.sv
`default_nettype none
module rps_scan (
  input  wire logic [rps_pkg::TimeW-1:0] now_i,
  input  wire logic [15:0]               arr_i,
  input  wire logic [7:0]                pri_i,
  input  wire logic                      admitted_i,
  input  wire logic                      done_i,
  input  wire logic                      is_active_i,
  input  wire logic                      best_v_i,
  input  wire logic [7:0]                best_pri_i,
  input  wire logic [15:0]               best_arr_i,
  output rps_pkg::scan_res_t             res_o
);

  always_comb begin
    res_o.admit    = !admitted_i && ({7'b0, arr_i} <= now_i);
    res_o.eligible = admitted_i && !done_i && !is_active_i;
    res_o.better   = !best_v_i || (pri_i < best_pri_i) ||
                     ((pri_i == best_pri_i) && (arr_i < best_arr_i));
  end

endmodule
`default_nettype wire

### rtl/core/rr_and_priority_tick_scheduler.sv
// Tick-driven process scheduler, round-robin (mode 0) or preemptive priority
// (mode 1). One command word in gives one result word out. Start copies each
// burst into remaining, one entry per cycle. A running tick walks the table
// once for admission and, in priority mode, once more through the shared
// compare unit for the best ready entry; in round-robin mode a tick that runs
// a unit adds a post-unit admission pass. Tables sit in single-port-write
// RAMs with registered reads.
`default_nettype none
module rr_and_priority_tick_scheduler #(
  parameter int unsigned MAX_PROCS = rps_pkg::MaxProcsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rps_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rps_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i
);

  localparam int unsigned SW = $clog2(MAX_PROCS);
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned TW = rps_pkg::TimeW;
  localparam int unsigned PW = rps_pkg::PidW;

  rps_pkg::state_e state_q, state_d;
  rps_pkg::in_word_t item_q, item_d;
  rps_pkg::out_word_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [CW-1:0] count_q, count_d, idx_q, idx_d, fill_q, fill_d, done_cnt_q, done_cnt_d;
  logic [SW-1:0] pidx_q, pidx_d, head_q, head_d, tail_q, tail_d, act_q, act_d;
  logic [SW-1:0] best_q, best_d;
  logic pv_q, pv_d, act_v_q, act_v_d, run_q, run_d, mode_q, mode_d;
  logic adm_post_q, adm_post_d, best_v_q, best_v_d, rem_zero_q, rem_zero_d;
  logic [TW-1:0] now_q, now_d, ta_q, ta_d;
  logic [15:0] slice_q, slice_d, quantum_q, quantum_d, best_arr_q, best_arr_d;
  logic [7:0] best_pri_q, best_pri_d, act_pri_q, act_pri_d;
  logic [MAX_PROCS-1:0] admitted_q, admitted_d, done_q, done_d, started_q, started_d;

  logic arr_we, bur_we, pri_we, rem_we, fs_we, fifo_we;
  logic [SW-1:0] arr_wa, bur_wa, rem_wa, fs_wa;
  logic [SW-1:0] arr_ra, bur_ra, rem_ra, fs_ra;
  logic [15:0] rem_wd, arr_rd, bur_rd, rem_rd;
  logic [7:0] pri_rd;
  logic [TW-1:0] fs_rd;
  logic [SW-1:0] fifo_rd, push_slot;
  logic push_en;
  logic scan_end, preempt;
  logic [15:0] q_eff;
  rps_pkg::scan_res_t scan;

  assign scan_end = (idx_q == count_q) && !pv_q;
  assign preempt  = best_v_q && (best_pri_q < act_pri_q);
  assign q_eff    = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
  assign in_stall_o  = (state_q != rps_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  rps_ram #(.Width(16), .Depth(MAX_PROCS)) u_arr (
    .clk_i, .we_i(arr_we), .waddr_i(arr_wa), .wdata_i(item_q.arrival),
    .raddr_i(arr_ra), .rdata_o(arr_rd));
  rps_ram #(.Width(16), .Depth(MAX_PROCS)) u_bur (
    .clk_i, .we_i(bur_we), .waddr_i(bur_wa), .wdata_i(item_q.burst),
    .raddr_i(bur_ra), .rdata_o(bur_rd));
  rps_ram #(.Width(8), .Depth(MAX_PROCS)) u_pri (
    .clk_i, .we_i(pri_we), .waddr_i(arr_wa), .wdata_i(item_q.priority_req),
    .raddr_i(idx_q[SW-1:0]), .rdata_o(pri_rd));
  rps_ram #(.Width(16), .Depth(MAX_PROCS)) u_rem (
    .clk_i, .we_i(rem_we), .waddr_i(rem_wa), .wdata_i(rem_wd),
    .raddr_i(rem_ra), .rdata_o(rem_rd));
  rps_ram #(.Width(TW), .Depth(MAX_PROCS)) u_fs (
    .clk_i, .we_i(fs_we), .waddr_i(fs_wa), .wdata_i(now_q),
    .raddr_i(fs_ra), .rdata_o(fs_rd));
  rps_ram #(.Width(SW), .Depth(MAX_PROCS)) u_fifo (
    .clk_i, .we_i(fifo_we), .waddr_i(tail_q), .wdata_i(push_slot),
    .raddr_i(head_q), .rdata_o(fifo_rd));

  rps_scan u_scan (
    .now_i(now_q), .arr_i(arr_rd), .pri_i(pri_rd),
    .admitted_i(admitted_q[pidx_q]), .done_i(done_q[pidx_q]),
    .is_active_i(act_v_q && (pidx_q == act_q)),
    .best_v_i(best_v_q), .best_pri_i(best_pri_q), .best_arr_i(best_arr_q),
    .res_o(scan));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rps_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_word_i.cmd)
            rps_pkg::CMD_ADD: begin
              if (in_word_i.burst == 16'd0 || count_q >= CW'(MAX_PROCS) || run_q) begin
                state_d = rps_pkg::S_OUT;
              end else begin
                state_d = rps_pkg::S_ADD;
              end
            end
            rps_pkg::CMD_START: begin
              state_d = (count_q == '0) ? rps_pkg::S_OUT : rps_pkg::S_COPY;
            end
            rps_pkg::CMD_TICK: begin
              state_d = run_q ? rps_pkg::S_ADM : rps_pkg::S_OUT;
            end
            rps_pkg::CMD_CLEAR: begin
              state_d = rps_pkg::S_OUT;
            end
            default: state_d = rps_pkg::S_OUT;
          endcase
        end
      end
      rps_pkg::S_ADD: state_d = rps_pkg::S_OUT;
      rps_pkg::S_COPY: begin
        if (scan_end) state_d = rps_pkg::S_OUT;
      end
      rps_pkg::S_ADM: begin
        if (scan_end) begin
          if (adm_post_q) state_d = rps_pkg::S_FIN1;
          else if (mode_q) state_d = rps_pkg::S_BEST;
          else if (act_v_q) state_d = rps_pkg::S_RUN1;
          else if (fill_q != '0) state_d = rps_pkg::S_POP1;
          else state_d = rps_pkg::S_OUT;
        end
      end
      rps_pkg::S_BEST: begin
        if (scan_end) begin
          if (act_v_q) state_d = preempt ? rps_pkg::S_PICK : rps_pkg::S_RUN1;
          else state_d = best_v_q ? rps_pkg::S_PICK : rps_pkg::S_OUT;
        end
      end
      rps_pkg::S_POP1: state_d = rps_pkg::S_POP2;
      rps_pkg::S_POP2: state_d = rps_pkg::S_PICK;
      rps_pkg::S_PICK: state_d = rps_pkg::S_RUN1;
      rps_pkg::S_RUN1: state_d = rps_pkg::S_RUN2;
      rps_pkg::S_RUN2: state_d = mode_q ? rps_pkg::S_FIN1 : rps_pkg::S_ADM;
      rps_pkg::S_FIN1: state_d = rps_pkg::S_FIN2;
      rps_pkg::S_FIN2: state_d = rps_pkg::S_FIN3;
      rps_pkg::S_FIN3: state_d = rps_pkg::S_OUT;
      rps_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = rps_pkg::S_IDLE;
      end
      default: state_d = rps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_d = item_q; res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    count_d = count_q; idx_d = idx_q; pidx_d = pidx_q; pv_d = pv_q;
    fill_d = fill_q; done_cnt_d = done_cnt_q; head_d = head_q; tail_d = tail_q;
    act_d = act_q; act_v_d = act_v_q; best_d = best_q; run_d = run_q; mode_d = mode_q;
    adm_post_d = adm_post_q; best_v_d = best_v_q; rem_zero_d = rem_zero_q;
    now_d = now_q; ta_d = ta_q; slice_d = slice_q; quantum_d = quantum_q;
    best_arr_d = best_arr_q; best_pri_d = best_pri_q; act_pri_d = act_pri_q;
    admitted_d = admitted_q; done_d = done_q; started_d = started_q;
    arr_we = 1'b0; bur_we = 1'b0; pri_we = 1'b0; rem_we = 1'b0; fs_we = 1'b0;
    arr_wa = count_q[SW-1:0]; bur_wa = count_q[SW-1:0];
    rem_wa = count_q[SW-1:0]; rem_wd = item_q.burst; fs_wa = best_q;
    arr_ra = idx_q[SW-1:0]; bur_ra = idx_q[SW-1:0]; rem_ra = act_q; fs_ra = act_q;
    push_en = 1'b0; push_slot = pidx_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == rps_pkg::CFG_MODE) begin
        if (!run_q) mode_d = cfg_wdata_i[0];
      end else begin
        quantum_d = cfg_wdata_i;
      end
    end

    unique case (state_q) inside
      rps_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_word_i;
          res_d = '0;
          idx_d = '0; pv_d = 1'b0; adm_post_d = 1'b0; best_v_d = 1'b0;
          unique case (in_word_i.cmd) inside
            rps_pkg::CMD_ADD: begin
              if (in_word_i.burst == 16'd0 || count_q >= CW'(MAX_PROCS) || run_q) begin
                res_d.status = rps_pkg::ST_REJECTED;
              end else begin
                res_d.status = rps_pkg::ST_ADDED;
                res_d.pid = PW'(count_q + 1'b1);
              end
            end
            rps_pkg::CMD_START, rps_pkg::CMD_CLEAR: begin
              if (in_word_i.cmd == rps_pkg::CMD_START && count_q == '0) begin
                res_d.status = rps_pkg::ST_EMPTY;
              end else begin
                admitted_d = '0; done_d = '0; started_d = '0;
                now_d = '0; head_d = '0; tail_d = '0; fill_d = '0;
                act_d = '0; act_v_d = 1'b0; slice_d = '0; done_cnt_d = '0;
                if (in_word_i.cmd == rps_pkg::CMD_START) begin
                  run_d = 1'b1;
                  res_d.status = rps_pkg::ST_RUN_STARTED;
                end else begin
                  run_d = 1'b0;
                  count_d = '0;
                  res_d.status = rps_pkg::ST_CLEARED;
                end
              end
            end
            rps_pkg::CMD_TICK: begin
              res_d.start_time = now_q;
              if (!run_q) begin
                res_d.status = (count_q == '0) ? rps_pkg::ST_EMPTY : rps_pkg::ST_ALL_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      rps_pkg::S_ADD: begin
        arr_we = 1'b1; bur_we = 1'b1; pri_we = 1'b1; rem_we = 1'b1;
        admitted_d[count_q[SW-1:0]] = 1'b0;
        done_d[count_q[SW-1:0]] = 1'b0;
        started_d[count_q[SW-1:0]] = 1'b0;
        count_d = count_q + 1'b1;
      end
      rps_pkg::S_COPY, rps_pkg::S_ADM, rps_pkg::S_BEST: begin
        if (idx_q != count_q) begin
          pv_d = 1'b1; pidx_d = idx_q[SW-1:0]; idx_d = idx_q + 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if (state_q == rps_pkg::S_COPY) begin
            rem_we = 1'b1; rem_wa = pidx_q; rem_wd = bur_rd;
          end else if (state_q == rps_pkg::S_ADM) begin
            if (scan.admit) begin
              admitted_d[pidx_q] = 1'b1;
              push_en = !mode_q;
            end
          end else if (scan.eligible && scan.better) begin
            best_v_d = 1'b1; best_d = pidx_q;
            best_pri_d = pri_rd; best_arr_d = arr_rd;
          end
        end
        if (scan_end) begin
          idx_d = '0;
          if (state_q == rps_pkg::S_ADM && !adm_post_q) begin
            best_v_d = 1'b0;
            if (!mode_q && !act_v_q && fill_q == '0) begin
              now_d = now_q + 1'b1;
              res_d.status = rps_pkg::ST_CPU_IDLE;
            end
          end else if (state_q == rps_pkg::S_BEST) begin
            if (act_v_q) begin
              if (preempt) begin
                res_d.preempted_pid = PW'(act_q) + 1'b1;
                act_v_d = 1'b0;
              end
            end else if (!best_v_q) begin
              now_d = now_q + 1'b1;
              res_d.status = rps_pkg::ST_CPU_IDLE;
            end
          end
        end
      end
      rps_pkg::S_POP1: ;
      rps_pkg::S_POP2: begin
        best_d = fifo_rd;
        head_d = (head_q == SW'(MAX_PROCS - 1)) ? '0 : head_q + 1'b1;
        fill_d = fill_q - 1'b1;
      end
      rps_pkg::S_PICK: begin
        act_d = best_q; act_v_d = 1'b1; slice_d = '0; act_pri_d = best_pri_q;
        if (!started_q[best_q]) begin
          started_d[best_q] = 1'b1;
          fs_we = 1'b1;
        end
      end
      rps_pkg::S_RUN1: ;
      rps_pkg::S_RUN2: begin
        rem_we = 1'b1; rem_wa = act_q; rem_wd = rem_rd - 1'b1;
        rem_zero_d = (rem_rd == 16'd1);
        if (slice_q != 16'hFFFF) slice_d = slice_q + 1'b1;
        now_d = now_q + 1'b1;
        res_d.status = rps_pkg::ST_RAN_UNIT;
        res_d.pid = PW'(act_q) + 1'b1;
        adm_post_d = 1'b1; idx_d = '0; pv_d = 1'b0;
      end
      rps_pkg::S_FIN1: begin
        arr_ra = act_q; bur_ra = act_q;
      end
      rps_pkg::S_FIN2: begin
        bur_ra = act_q;
        ta_d = now_q - {7'b0, arr_rd};
        if (rem_zero_q) begin
          res_d.turnaround = now_q - {7'b0, arr_rd};
          res_d.response = fs_rd - {7'b0, arr_rd};
        end
      end
      rps_pkg::S_FIN3: begin
        if (rem_zero_q) begin
          res_d.completed = 1'b1;
          res_d.waiting = ta_q - {7'b0, bur_rd};
          done_d[act_q] = 1'b1;
          act_v_d = 1'b0;
          done_cnt_d = done_cnt_q + 1'b1;
          if (done_cnt_q + 1'b1 >= count_q) run_d = 1'b0;
        end else if (!mode_q && slice_q >= q_eff) begin
          res_d.quantum_expired = 1'b1;
          push_en = 1'b1; push_slot = act_q;
          act_v_d = 1'b0;
        end
      end
      rps_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = res_q; out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    fifo_we = push_en && (fill_q < CW'(MAX_PROCS));
    if (fifo_we) begin
      tail_d = (tail_q == SW'(MAX_PROCS - 1)) ? '0 : tail_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rps_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      count_q <= '0; idx_q <= '0; pv_q <= 1'b0; fill_q <= '0; done_cnt_q <= '0;
      head_q <= '0; tail_q <= '0; act_q <= '0; act_v_q <= 1'b0; run_q <= 1'b0;
      mode_q <= 1'b0; quantum_q <= 16'd2; adm_post_q <= 1'b0; best_v_q <= 1'b0;
      now_q <= '0; slice_q <= '0;
      admitted_q <= '0; done_q <= '0; started_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      count_q <= count_d; idx_q <= idx_d; pv_q <= pv_d; fill_q <= fill_d;
      done_cnt_q <= done_cnt_d; head_q <= head_d; tail_q <= tail_d;
      act_q <= act_d; act_v_q <= act_v_d; run_q <= run_d; mode_q <= mode_d;
      quantum_q <= quantum_d; adm_post_q <= adm_post_d; best_v_q <= best_v_d;
      now_q <= now_d; slice_q <= slice_d;
      admitted_q <= admitted_d; done_q <= done_d; started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; res_q <= res_d; out_q <= out_d; pidx_q <= pidx_d;
    best_q <= best_d; rem_zero_q <= rem_zero_d; ta_q <= ta_d;
    best_arr_q <= best_arr_d; best_pri_q <= best_pri_d; act_pri_q <= act_pri_d;
  end

  a_active_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_v_q |-> run_q) else $error("active process outside a run");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_PROCS)) else $error("ready queue overfilled");
  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_cnt_q <= count_q) else $error("more completions than entries");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rps_pkg::S_OUT && state_d == rps_pkg::S_IDLE) |=> out_valid_q)
    else $error("result word lost");

endmodule
`default_nettype wire

### tb/sv/rr_and_priority_tick_scheduler_test.sv
`default_nettype none
module rr_and_priority_tick_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = int'(rps_pkg::MaxProcsDef);
  localparam int PW = rps_pkg::PidW;
  localparam int TW = rps_pkg::TimeW;
  localparam int unsigned TMASK = 32'h7FFFFF;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rps_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rps_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [15:0] cfg_wdata = '0;

  rr_and_priority_tick_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  initial forever #5 clk_i = ~clk_i;

  // scheduler image
  int unsigned tbl_arr[NSLOT], tbl_burst[NSLOT], tbl_prio[NSLOT], tbl_rem[NSLOT];
  int unsigned tbl_first[NSLOT];
  bit tbl_adm[NSLOT], tbl_done[NSLOT], tbl_started[NSLOT];
  int unsigned n_entries, now_t, rq[NSLOT], rq_head, rq_tail, rq_fill;
  int unsigned run_slot, slice_cnt, n_done, sched_mode, sched_quantum;
  bit run_slot_valid, run_on;

  rps_pkg::out_word_t expected_q[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  int n_items = 0;
  longint cycles = 0;

  function automatic void clear_run();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_adm[i] = 0; tbl_done[i] = 0; tbl_started[i] = 0;
    end
    now_t = 0; rq_head = 0; rq_tail = 0; rq_fill = 0;
    run_slot = 0; run_slot_valid = 0; slice_cnt = 0; n_done = 0; run_on = 0;
  endfunction

  function automatic void rq_push(int unsigned s);
    if (rq_fill >= NSLOT) return;
    rq[rq_tail] = s;
    rq_tail = (rq_tail + 1 >= NSLOT) ? 0 : rq_tail + 1;
    rq_fill++;
  endfunction

  function automatic void admit_arrivals(int unsigned t);
    for (int i = 0; i < n_entries; i++)
      if (!tbl_adm[i] && tbl_arr[i] <= t) begin
        tbl_adm[i] = 1;
        if (sched_mode == 0) rq_push(32'(i));
      end
  endfunction

  function automatic int unsigned best_ready();
    int unsigned best;
    best = NSLOT;
    for (int i = 0; i < n_entries; i++) begin
      if (!tbl_adm[i] || tbl_done[i]) continue;
      if (run_slot_valid && i == run_slot) continue;
      if (best == NSLOT || tbl_prio[i] < tbl_prio[best] ||
          (tbl_prio[i] == tbl_prio[best] && tbl_arr[i] < tbl_arr[best]))
        best = 32'(i);
    end
    return best;
  endfunction

  function automatic rps_pkg::out_word_t schedule_word(rps_pkg::in_word_t w);
    rps_pkg::out_word_t o;
    int unsigned pick, b, ta;
    o = '0;
    if (w.cmd == rps_pkg::CMD_ADD) begin
      if (w.burst == 0 || n_entries >= NSLOT || run_on) begin
        o.status = rps_pkg::ST_REJECTED;
        return o;
      end
      tbl_arr[n_entries] = 32'(w.arrival); tbl_burst[n_entries] = 32'(w.burst);
      tbl_prio[n_entries] = 32'(w.priority_req); tbl_rem[n_entries] = 32'(w.burst);
      tbl_first[n_entries] = 0; tbl_adm[n_entries] = 0;
      tbl_done[n_entries] = 0; tbl_started[n_entries] = 0;
      n_entries++;
      o.status = rps_pkg::ST_ADDED;
      o.pid = PW'(n_entries);
      return o;
    end
    if (w.cmd == rps_pkg::CMD_START) begin
      if (n_entries == 0) begin
        o.status = rps_pkg::ST_EMPTY;
        return o;
      end
      clear_run();
      for (int i = 0; i < n_entries; i++) tbl_rem[i] = tbl_burst[i];
      run_on = 1;
      o.status = rps_pkg::ST_RUN_STARTED;
      return o;
    end
    if (w.cmd == rps_pkg::CMD_CLEAR) begin
      n_entries = 0;
      clear_run();
      o.status = rps_pkg::ST_CLEARED;
      return o;
    end
    o.start_time = TW'(now_t);
    if (!run_on) begin
      o.status = (n_entries == 0) ? rps_pkg::ST_EMPTY : rps_pkg::ST_ALL_DONE;
      return o;
    end
    admit_arrivals(now_t);
    if (sched_mode == 1 && run_slot_valid) begin
      b = best_ready();
      if (b < NSLOT && tbl_prio[b] < tbl_prio[run_slot]) begin
        o.preempted_pid = PW'(run_slot + 1);
        run_slot_valid = 0;
      end
    end
    if (!run_slot_valid) begin
      pick = NSLOT;
      if (sched_mode == 0) begin
        if (rq_fill > 0) begin
          pick = rq[rq_head];
          rq_head = (rq_head + 1 >= NSLOT) ? 0 : rq_head + 1;
          rq_fill--;
        end
      end else pick = best_ready();
      if (pick >= NSLOT) begin
        now_t = (now_t + 1) & TMASK;
        o.status = rps_pkg::ST_CPU_IDLE;
        return o;
      end
      run_slot = pick; run_slot_valid = 1; slice_cnt = 0;
      if (!tbl_started[pick]) begin
        tbl_started[pick] = 1;
        tbl_first[pick] = now_t;
      end
    end
    tbl_rem[run_slot] = (tbl_rem[run_slot] - 1) & 16'hFFFF;
    if (slice_cnt < 16'hFFFF) slice_cnt++;
    now_t = (now_t + 1) & TMASK;
    o.status = rps_pkg::ST_RAN_UNIT;
    o.pid = PW'(run_slot + 1);
    if (sched_mode == 0) admit_arrivals(now_t);
    if (tbl_rem[run_slot] == 0) begin
      ta = (now_t - tbl_arr[run_slot]) & TMASK;
      tbl_done[run_slot] = 1;
      o.completed = 1;
      o.turnaround = TW'(ta);
      o.waiting = TW'((ta - tbl_burst[run_slot]) & TMASK);
      o.response = TW'((tbl_first[run_slot] - tbl_arr[run_slot]) & TMASK);
      run_slot_valid = 0;
      n_done++;
      if (n_done >= n_entries) run_on = 0;
    end else if (sched_mode == 0 && slice_cnt >= (sched_quantum ? sched_quantum : 1)) begin
      o.quantum_expired = 1;
      rq_push(run_slot);
      run_slot_valid = 0;
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [15:0] burst = 0,
                           logic [7:0] prio = 0, logic [15:0] arrival = 0);
    rps_pkg::in_word_t w;
    int gap;
    w.cmd = cmd; w.burst = burst; w.priority_req = prio; w.arrival = arrival;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    expected_q = {expected_q, schedule_word(w)};
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic cfg_write(rps_pkg::cfg_idx_e idx, logic [15:0] value);
    drain();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == rps_pkg::CFG_MODE) begin
      if (!run_on) sched_mode = 32'(value[0]);
    end else sched_quantum = 32'(value);
  endtask

  task automatic tick(int n);
    repeat (n) send_word(rps_pkg::CMD_TICK);
  endtask

  task automatic run_to_end(int guard);
    while (run_on && guard > 0) begin
      send_word(rps_pkg::CMD_TICK);
      guard--;
    end
    tick(2);
  endtask

  // receiver stalls and result checking
  int stall_left = 0;
  always @(posedge clk_i) begin
    rps_pkg::out_word_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (out_word.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_word.status); failed = 1'b1;
        end
        if (out_word.pid !== e.pid) begin
          $error("pid exp %0d got %0d", e.pid, out_word.pid); failed = 1'b1;
        end
        if (out_word.start_time !== e.start_time) begin
          $error("start_time exp %0d got %0d", e.start_time, out_word.start_time);
          failed = 1'b1;
        end
        if (out_word.preempted_pid !== e.preempted_pid) begin
          $error("preempted_pid exp %0d got %0d", e.preempted_pid, out_word.preempted_pid);
          failed = 1'b1;
        end
        if (out_word.quantum_expired !== e.quantum_expired) begin
          $error("quantum_expired exp %0d got %0d", e.quantum_expired,
                 out_word.quantum_expired);
          failed = 1'b1;
        end
        if (out_word.completed !== e.completed) begin
          $error("completed exp %0d got %0d", e.completed, out_word.completed);
          failed = 1'b1;
        end
        if (out_word.turnaround !== e.turnaround) begin
          $error("turnaround exp %0d got %0d", e.turnaround, out_word.turnaround);
          failed = 1'b1;
        end
        if (out_word.waiting !== e.waiting) begin
          $error("waiting exp %0d got %0d", e.waiting, out_word.waiting); failed = 1'b1;
        end
        if (out_word.response !== e.response) begin
          $error("response exp %0d got %0d", e.response, out_word.response);
          failed = 1'b1;
        end
      end
    end
    if (quiet) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 65) out_stall <= 1'b0;
      else begin
        out_stall <= 1'b1;
        stall_left = (r < 95) ? int'($urandom_range(0, 2)) : int'($urandom_range(10, 50));
      end
    end
  end

  task automatic test_empty_table();
    send_word(rps_pkg::CMD_TICK);
    send_word(rps_pkg::CMD_START);
    send_word(rps_pkg::CMD_ADD, 16'd0, 8'd3, 16'd0);
    send_word(rps_pkg::CMD_CLEAR);
  endtask

  task automatic test_round_robin();
    cfg_write(rps_pkg::CFG_MODE, 16'd0);
    cfg_write(rps_pkg::CFG_QUANTUM, 16'd2);
    send_word(rps_pkg::CMD_ADD, 16'd3, 8'd0, 16'd0);
    send_word(rps_pkg::CMD_ADD, 16'd1, 8'd255, 16'd1);
    send_word(rps_pkg::CMD_ADD, 16'd2, 8'd7, 16'd2);
    send_word(rps_pkg::CMD_START);
    send_word(rps_pkg::CMD_ADD, 16'd4, 8'd1, 16'd0);
    tick(3);
    send_word(rps_pkg::CMD_START);
    run_to_end(40);
  endtask

  task automatic test_priority();
    cfg_write(rps_pkg::CFG_MODE, 16'd1);
    send_word(rps_pkg::CMD_CLEAR);
    send_word(rps_pkg::CMD_ADD, 16'd4, 8'd5, 16'd0);
    send_word(rps_pkg::CMD_ADD, 16'd2, 8'd1, 16'd2);
    send_word(rps_pkg::CMD_ADD, 16'd1, 8'd5, 16'd0);
    send_word(rps_pkg::CMD_ADD, 16'd2, 8'd5, 16'd1);
    send_word(rps_pkg::CMD_START);
    cfg_write(rps_pkg::CFG_MODE, 16'd0);
    run_to_end(40);
  endtask

  task automatic test_extremes();
    send_word(rps_pkg::CMD_CLEAR);
    send_word(rps_pkg::CMD_ADD, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_word(rps_pkg::CMD_ADD, 16'h5555, 8'hAA, 16'h0000);
    send_word(rps_pkg::CMD_ADD, 16'hAAAA, 8'h55, 16'h0003);
    send_word(rps_pkg::CMD_START);
    tick(6);
    send_word(rps_pkg::CMD_CLEAR);
    send_word(rps_pkg::CMD_TICK);
  endtask

  task automatic test_quantum_edges();
    cfg_write(rps_pkg::CFG_MODE, 16'd0);
    for (int k = 0; k < 2; k++) begin
      cfg_write(rps_pkg::CFG_QUANTUM, k == 0 ? 16'd0 : 16'hFFFF);
      send_word(rps_pkg::CMD_CLEAR);
      send_word(rps_pkg::CMD_ADD, 16'd3, 8'd0, 16'd0);
      send_word(rps_pkg::CMD_ADD, 16'd2, 8'd0, 16'd0);
      send_word(rps_pkg::CMD_START);
      run_to_end(20);
    end
  endtask

  task automatic test_table_full();
    cfg_write(rps_pkg::CFG_QUANTUM, 16'd1);
    send_word(rps_pkg::CMD_CLEAR);
    for (int i = 0; i <= NSLOT; i++)
      send_word(rps_pkg::CMD_ADD, 16'd1, 8'($urandom_range(0, 3)),
                16'($urandom_range(0, 4)));
    send_word(rps_pkg::CMD_START);
    run_to_end(NSLOT + 10);
  endtask

  task automatic test_random(int target);
    logic [15:0] qv;
    int n, r;
    while (n_items < target) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) cfg_write(rps_pkg::CFG_MODE, 16'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        r = int'($urandom_range(0, 5));
        qv = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'($urandom)
           : 16'($urandom_range(1, 4));
        cfg_write(rps_pkg::CFG_QUANTUM, qv);
      end
      send_word(rps_pkg::CMD_CLEAR);
      n = int'($urandom_range(1, 8));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_word(rps_pkg::CMD_ADD, 16'($urandom), 8'($urandom), 16'($urandom));
        else
          send_word(rps_pkg::CMD_ADD, 16'($urandom_range(0, 6)), 8'($urandom_range(0, 3)),
                    16'($urandom_range(0, 12)));
      end
      if ($urandom_range(0, 5) == 0) send_word(2'($urandom));
      send_word(rps_pkg::CMD_START);
      if ($urandom_range(0, 5) == 0) begin
        tick(int'($urandom_range(1, 5)));
        if ($urandom_range(0, 1) == 0) cfg_write(rps_pkg::CFG_MODE, 16'($urandom));
        if ($urandom_range(0, 1) == 0) send_word(rps_pkg::CMD_ADD, 16'd2, 8'd0, 16'd0);
        else send_word(rps_pkg::CMD_START);
      end
      run_to_end(60);
    end
    quiet = 1'b0;
  endtask

  initial begin
    int guard;
    sched_mode = 0;
    sched_quantum = 2;
    n_entries = 0;
    clear_run();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_round_robin();
    test_priority();
    test_extremes();
    test_quantum_edges();
    test_table_full();
    test_random(500);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
    if (!failed && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_q.size() != 0) $error("%0d result words never arrived", expected_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
